// ===== sv/aepq_pkg.sv =====
// shared types and codes for the active/expired priority queue
package aepq_pkg;

  // request kinds carried on the slave tuser bit
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  // fixed field widths
  localparam int unsigned SPRIO_W = 3;
  localparam int unsigned DPRIO_W = 3;
  localparam int unsigned STAT_W  = 2;

  // dynamic priority value that marks an expired quantum
  localparam logic [DPRIO_W-1:0] DYN_EXPIRED = 3'b111;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
    logic load;
  } aepq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } aepq_stat_t;

endpackage

// ===== sv/aepq_ctrl.sv =====
// controller state machine: sequences capture, queue update and result load
module aepq_ctrl import aepq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  aepq_stat_t stat,
  output aepq_cmd_t  cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_next = s_tvalid ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    s_tready    = 1'b0;
    cmd.execute = 1'b0;
    cmd.load    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
      end
      ST_DONE: begin
        s_tready = stat.out_free;
        cmd.load = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
    cmd.capture = s_tvalid & s_tready;
  end

endmodule

// ===== sv/aepq_dp.sv =====
// datapath: request registers, level heads and counts, slot memory, output register
module aepq_dp import aepq_pkg::*; #(
  parameter int NUM_LEVELS   = 4,
  parameter int LEVEL_DEPTH  = 64,
  parameter int TASK_ID_BITS = 8,
  localparam int LW = $clog2(NUM_LEVELS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  aepq_cmd_t               cmd,
  output aepq_stat_t              stat,
  input  logic                    req_type,
  input  logic [TASK_ID_BITS-1:0] task_id,
  input  logic [SPRIO_W-1:0]      static_prio,
  input  logic [DPRIO_W-1:0]      dyn_prio,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic                    grant_valid,
  output logic [TASK_ID_BITS-1:0] out_task,
  output logic [LW-1:0]           out_prio,
  output logic                    to_expired,
  output status_t                 status
);

  localparam int TW        = TASK_ID_BITS;
  localparam int PW        = $clog2(LEVEL_DEPTH);
  localparam int CW        = $clog2(LEVEL_DEPTH + 1);
  localparam int MEM_DEPTH = 2 * NUM_LEVELS * LEVEL_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam logic signed [5:0] LVL_MAX = 6'(NUM_LEVELS - 1);

  // captured request
  logic                 req_r;
  logic [TW-1:0]        tid_r;
  logic [SPRIO_W-1:0]   sprio_r;
  logic [DPRIO_W-1:0]   dprio_r;

  // queue state
  logic                 bank;
  logic [PW-1:0]        heads  [2][NUM_LEVELS];
  logic [CW-1:0]        counts [2][NUM_LEVELS];
  logic [TW-1:0]        mem    [MEM_DEPTH];
  logic [TW-1:0]        rd_data;

  // result held between execute and load
  logic                 res_grant;
  logic [TW-1:0]        res_task;
  logic [LW-1:0]        res_prio;
  logic                 res_exp;
  status_t              res_status;
  logic                 res_from_mem;

  // add path signals
  logic                 expired;
  logic signed [5:0]    lvl_raw;
  logic [LW-1:0]        add_lvl;
  logic                 add_bank;
  logic                 add_full;
  logic [PW:0]          tail_sum;
  logic [PW-1:0]        tail;

  // take path signals
  logic [NUM_LEVELS-1:0] ne0, ne1, ne_act, ne_eff;
  logic                  act_empty;
  logic                  eff_bank;
  logic                  found;
  logic [LW-1:0]         take_lvl;
  logic [PW-1:0]         take_head;
  logic [PW-1:0]         head_next;

  // memory access
  logic                 is_add;
  logic                 acc_bank;
  logic [LW-1:0]        acc_lvl;
  logic [PW-1:0]        acc_pos;
  logic [AW-1:0]        acc_addr;
  logic                 mem_we;
  logic                 mem_re;

  assign is_add = (req_r == REQ_ADD);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= req_type;
      tid_r   <= task_id;
      sprio_r <= static_prio;
      dprio_r <= dyn_prio;
    end
  end

  // add: target level and bank with saturation
  always_comb begin
    expired = (dprio_r == DYN_EXPIRED);
    if (expired) begin
      lvl_raw = $signed({3'b000, sprio_r}) - 6'sd1;
    end else begin
      lvl_raw = $signed({{3{dprio_r[DPRIO_W-1]}}, dprio_r});
    end
    if (lvl_raw < 6'sd0) begin
      add_lvl = '0;
    end else if (lvl_raw > LVL_MAX) begin
      add_lvl = LW'(NUM_LEVELS - 1);
    end else begin
      add_lvl = LW'(lvl_raw);
    end
    add_bank = bank ^ expired;
    add_full = (counts[add_bank][add_lvl] == CW'(LEVEL_DEPTH));
    tail_sum = {1'b0, heads[add_bank][add_lvl]} + (PW+1)'(counts[add_bank][add_lvl]);
    if (tail_sum >= (PW+1)'(LEVEL_DEPTH)) begin
      tail = PW'(tail_sum - (PW+1)'(LEVEL_DEPTH));
    end else begin
      tail = PW'(tail_sum);
    end
  end

  // take: bank swap when active is empty, then highest non-empty level
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      ne0[i] = (counts[0][i] != '0);
      ne1[i] = (counts[1][i] != '0);
    end
    ne_act    = bank ? ne1 : ne0;
    act_empty = ~|ne_act;
    eff_bank  = bank ^ act_empty;
    ne_eff    = eff_bank ? ne1 : ne0;
    found     = 1'b0;
    take_lvl  = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (ne_eff[i]) begin
        found    = 1'b1;
        take_lvl = LW'(i);
      end
    end
    take_head = heads[eff_bank][take_lvl];
    if (take_head == PW'(LEVEL_DEPTH - 1)) begin
      head_next = '0;
    end else begin
      head_next = take_head + PW'(1);
    end
  end

  // slot address: queue number times depth plus position
  always_comb begin
    acc_bank = is_add ? add_bank : eff_bank;
    acc_lvl  = is_add ? add_lvl  : take_lvl;
    acc_pos  = is_add ? tail     : take_head;
    acc_addr = (AW'(acc_bank) * AW'(NUM_LEVELS) + AW'(acc_lvl)) * AW'(LEVEL_DEPTH)
               + AW'(acc_pos);
    mem_we   = cmd.execute & is_add & ~add_full;
    mem_re   = cmd.execute & ~is_add & found;
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[acc_addr] <= tid_r;
    if (mem_re) rd_data <= mem[acc_addr];
  end

  // bank select, heads and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
      for (int b = 0; b < 2; b++) begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
          heads[b][l]  <= '0;
          counts[b][l] <= '0;
        end
      end
    end else if (cmd.execute) begin
      if (is_add) begin
        if (!add_full) counts[add_bank][add_lvl] <= counts[add_bank][add_lvl] + CW'(1);
      end else begin
        bank <= eff_bank;
        if (found) begin
          heads[eff_bank][take_lvl]  <= head_next;
          counts[eff_bank][take_lvl] <= counts[eff_bank][take_lvl] - CW'(1);
        end
      end
    end
  end

  // result fields, settled during execute
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (is_add) begin
        res_grant    <= 1'b0;
        res_task     <= tid_r;
        res_prio     <= add_lvl;
        res_exp      <= expired;
        res_status   <= add_full ? STAT_FULL : STAT_OK;
        res_from_mem <= 1'b0;
      end else begin
        res_grant    <= found;
        res_task     <= '0;
        res_prio     <= found ? take_lvl : '0;
        res_exp      <= 1'b0;
        res_status   <= found ? STAT_OK : STAT_EMPTY;
        res_from_mem <= found;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      grant_valid <= res_grant;
      out_task    <= res_from_mem ? rd_data : res_task;
      out_prio    <= res_prio;
      to_expired  <= res_exp;
      status      <= res_status;
    end
  end

  assign stat.out_free = ~m_tvalid | m_tready;

endmodule

// ===== sv/active_expired_priority_queue_unit.sv =====
// one transaction in, one result out; the result is loaded into the output register after execute
// a new transaction is not accepted before the previous result loads, which follows the slot memory's registered read
// and the head/count update that precede the output register load
// a waiting result stalls the next transaction only at its load step
// reset (rst, synchronous, active high) clears bank select, heads, counts, fsm, output valid
// the slot memory is not cleared; only slots that hold queued tasks are read
module active_expired_priority_queue_unit import aepq_pkg::*; #(
  parameter int NUM_LEVELS   = 4,
  parameter int LEVEL_DEPTH  = 64,
  parameter int TASK_ID_BITS = 8,
  localparam int LW    = $clog2(NUM_LEVELS),
  localparam int IN_W  = ((TASK_ID_BITS + SPRIO_W + DPRIO_W + 7) / 8) * 8,
  localparam int OUT_W = ((TASK_ID_BITS + LW + 1 + STAT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // task_id, static_prio, dyn_prio, zero pad
  input  logic             s_tuser,   // req_type
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // out_task, out_prio, to_expired, status, zero pad
  output logic             m_tuser    // grant_valid
);

  localparam int TW     = TASK_ID_BITS;
  localparam int SP_LO  = TW;
  localparam int DP_LO  = TW + SPRIO_W;
  localparam int EXP_LO = TW + LW;
  localparam int ST_LO  = TW + LW + 1;

  aepq_cmd_t      cmd;
  aepq_stat_t     stat;
  logic [TW-1:0]  out_task;
  logic [LW-1:0]  out_prio;
  logic           to_expired;
  status_t        status;

  // controller
  aepq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  aepq_dp #(
    .NUM_LEVELS   (NUM_LEVELS),
    .LEVEL_DEPTH  (LEVEL_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (s_tuser),
    .task_id     (s_tdata[TW-1:0]),
    .static_prio (s_tdata[SP_LO +: SPRIO_W]),
    .dyn_prio    (s_tdata[DP_LO +: DPRIO_W]),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .grant_valid (m_tuser),
    .out_task    (out_task),
    .out_prio    (out_prio),
    .to_expired  (to_expired),
    .status      (status)
  );

  // result packing
  assign m_tdata = OUT_W'({status, to_expired, out_prio, out_task});

`ifndef SYNTH
  // one transaction at a time: no accept right after an accept
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a transaction is in execute");

  // every accepted transaction is followed by its result being presented
  a_result_present: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> ##3 m_tvalid)
    else $error("result missing after accepted transaction");

  // a granted take always reports ok
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[ST_LO +: STAT_W] == STAT_OK))
    else $error("grant with non-ok status");

  // expired placement only comes from an add, never with a grant
  a_expired_no_grant: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[EXP_LO]) |-> !m_tuser)
    else $error("grant flagged as expired placement");
`endif

endmodule
